// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, constants and segment tables for the temperature formatter.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int RAW_W  = 16;
  localparam int SEG_W  = 8;
  localparam int IPART_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_NEG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LIMIT   = 1'b1;

  localparam logic [RAW_W-1:0]   NEG_THRESHOLD_RST = 16'd6348;
  localparam logic [IPART_W-1:0] ALARM_LIMIT_RST   = 8'd20;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;

  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } bcd_t;

  typedef struct packed {
    logic [SEG_W-1:0]   seg_tenths;
    logic [SEG_W-1:0]   seg_units;
    logic [SEG_W-1:0]   seg_tens;
    logic [SEG_W-1:0]   seg_hundreds;
    logic               is_negative;
    logic [IPART_W-1:0] ipart;
  } fmt_t;

  function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // sixteenths to nearest tenths, halves rounded up
  function automatic logic [3:0] tenths_digit(input logic [3:0] nib);
    logic [3:0] d;
    unique case (nib)
      4'd0:            d = 4'd0;
      4'd1, 4'd2:      d = 4'd1;
      4'd3:            d = 4'd2;
      4'd4, 4'd5:      d = 4'd3;
      4'd6, 4'd7:      d = 4'd4;
      4'd8:            d = 4'd5;
      4'd9, 4'd10:     d = 4'd6;
      4'd11:           d = 4'd7;
      4'd12, 4'd13:    d = 4'd8;
      default:         d = 4'd9;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/temperature_to_seven_segment.sv
// ----------------------------------------------------------------------------
// temperature_to_seven_segment
// Raw temperature reading to four seven-segment digit codes plus alarm.
// ----------------------------------------------------------------------------
// Path: an input transaction reaches the result transaction through the
//   input register, then the result register.
// Throughput: one transaction per cycle while the output side accepts; an
//   empty input stage still fills while a stalled result is held.
// Reset: synchronous rst_n clears valids and alarm, loads register defaults.
module temperature_to_seven_segment (
  input  logic                               clk,
  input  logic                               rst_n,
  // tdata[15:0] raw_reading
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tts_pkg::RAW_W-1:0]          in_tdata,
  // tdata[7:0] seg_tenths, [15:8] seg_units, [23:16] seg_tens,
  // [31:24] seg_hundreds, [32] is_negative, [33] alarm_out, [39:34] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tts_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [tts_pkg::RAW_W-1:0]   neg_threshold_r;
  logic [tts_pkg::IPART_W-1:0] alarm_limit_r;

  logic                        s1_valid_r;
  logic [tts_pkg::RAW_W-1:0]   s1_raw_r;

  logic                        out_valid_r;
  tts_pkg::fmt_t               out_fmt_r;
  logic                        alarm_r;
  logic                        alarm_nxt;

  tts_pkg::fmt_t               fmt;
  logic                        s2_load;
  logic                        s2_ready;
  logic                        in_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_threshold_r <= tts_pkg::NEG_THRESHOLD_RST;
      alarm_limit_r   <= tts_pkg::ALARM_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tts_pkg::CFG_NEG_THRESHOLD: neg_threshold_r <= cfg_data;
        tts_pkg::CFG_ALARM_LIMIT:   alarm_limit_r   <= cfg_data[tts_pkg::IPART_W-1:0];
        default: ;
      endcase
    end
  end

  assign s2_ready  = !out_valid_r || out_tready;
  assign s2_load   = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_raw_r <= in_tdata;
    end
  end

  tts_fmt u_fmt (
    .raw_reading   (s1_raw_r),
    .neg_threshold (neg_threshold_r),
    .fmt           (fmt)
  );

  assign alarm_nxt = (fmt.ipart > alarm_limit_r) ? !alarm_r : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      alarm_r     <= 1'b0;
    end else begin
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s2_load) begin
        alarm_r <= alarm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_fmt_r <= fmt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, alarm_r, out_fmt_r.is_negative,
                       out_fmt_r.seg_hundreds, out_fmt_r.seg_tens,
                       out_fmt_r.seg_units, out_fmt_r.seg_tenths};

endmodule

// File: rtl/tts_split.sv
// ----------------------------------------------------------------------------
// tts_split
// Splits an 8-bit integer into hundreds, tens and units digits.
// ----------------------------------------------------------------------------
module tts_split (
  input  logic [tts_pkg::IPART_W-1:0] ipart,
  output tts_pkg::bcd_t               bcd
);

  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  units;

  always_comb begin
    hund = 2'd0;
    rem  = ipart[6:0];
    if (ipart >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(ipart - 8'd200);
    end else if (ipart >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(ipart - 8'd100);
    end
  end

  // rem < 100: floor(rem / 10) == (rem * 205) >> 11
  assign tens_prod = 15'(rem) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = 7'(tens) * 7'd10;
  assign units     = 4'(rem - tens_x10);

  assign bcd = {hund, tens, units};

endmodule

// File: rtl/tts_fmt.sv
// ----------------------------------------------------------------------------
// tts_fmt
// Sign handling, digit split and segment encoding of one raw reading.
// ----------------------------------------------------------------------------
module tts_fmt (
  input  logic [tts_pkg::RAW_W-1:0] raw_reading,
  input  logic [tts_pkg::RAW_W-1:0] neg_threshold,
  output tts_pkg::fmt_t             fmt
);

  logic                              neg;
  logic [tts_pkg::RAW_W-1:0]         mag;
  logic [tts_pkg::IPART_W-1:0]       ipart;
  tts_pkg::bcd_t                     bcd;
  logic                              hund_zero;

  assign neg   = raw_reading > neg_threshold;
  assign mag   = neg ? 16'(~raw_reading + 16'd1) : raw_reading;
  assign ipart = mag[11:4];

  tts_split u_split (
    .ipart (ipart),
    .bcd   (bcd)
  );

  assign hund_zero = bcd.hund == 2'd0;

  always_comb begin
    fmt.seg_tenths   = tts_pkg::digit_seg(tts_pkg::tenths_digit(mag[3:0]));
    fmt.seg_units    = tts_pkg::digit_seg(bcd.units) | tts_pkg::SEG_DP;
    fmt.seg_tens     = (hund_zero && bcd.tens == 4'd0) ? tts_pkg::SEG_BLANK
                                                       : tts_pkg::digit_seg(bcd.tens);
    if (neg) begin
      fmt.seg_hundreds = tts_pkg::SEG_MINUS;
    end else if (hund_zero) begin
      fmt.seg_hundreds = tts_pkg::SEG_BLANK;
    end else begin
      fmt.seg_hundreds = tts_pkg::digit_seg({2'b00, bcd.hund});
    end
    fmt.is_negative  = neg;
    fmt.ipart        = ipart;
  end

endmodule

// File: rtl/tts_chk.sv
// ----------------------------------------------------------------------------
// tts_chk
// Port-level checks for the temperature formatter, bound to the top level.
// ----------------------------------------------------------------------------
module tts_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tts_pkg::OUT_DATA_W-1:0]     out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result transaction changed");

  a_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:24] == tts_pkg::SEG_MINUS)
    else $error("negative reading without minus sign");

  a_blank_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31:24] == tts_pkg::SEG_BLANK
      |-> !out_tdata[32] && out_tdata[15] && out_tdata[39:34] == 6'd0)
    else $error("blank hundreds with sign, missing point or stray pad bits");

endmodule

bind temperature_to_seven_segment tts_chk u_tts_chk (.*);

// File: verif/temperature_to_seven_segment_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// temperature_to_seven_segment_checker
// Watches the reading, display and register channels of the formatter. Every
// reading accepted on the input is formatted here into the expected digit
// codes and alarm level. The result is queued and compared field by field
// with the next display transaction. Mismatches, unexpected displays and the
// number of displays still outstanding are reported to the testbench top.
// ----------------------------------------------------------------------------
module temperature_to_seven_segment_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [tts_pkg::RAW_W-1:0]      in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [tts_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             pending_count
);

  typedef struct packed {
    logic [tts_pkg::SEG_W-1:0] seg_tenths;
    logic [tts_pkg::SEG_W-1:0] seg_units;
    logic [tts_pkg::SEG_W-1:0] seg_tens;
    logic [tts_pkg::SEG_W-1:0] seg_hundreds;
    logic                      is_negative;
    logic                      alarm_out;
  } display_t;

  // codes for digits 9 down to 0, digit 0 in the low byte
  localparam logic [79:0] DIGIT_SEGMENTS = {
    8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  display_t                  expected_displays [$];
  logic [tts_pkg::RAW_W-1:0] neg_threshold;
  logic [7:0]                alarm_limit;
  logic                      alarm_level;

  function automatic logic [tts_pkg::SEG_W-1:0] segments_of(input int digit);
    return DIGIT_SEGMENTS[digit*8 +: 8];
  endfunction

  function automatic display_t predict_display(input logic [tts_pkg::RAW_W-1:0] raw,
                                               input logic [tts_pkg::RAW_W-1:0] threshold,
                                               input logic [7:0] limit,
                                               input logic alarm_prev);
    display_t                  d;
    logic [tts_pkg::RAW_W-1:0] magnitude;
    logic [7:0]                degrees;
    int                        hund;
    int                        tens;
    int                        units;
    int                        tenths;
    d.is_negative = raw > threshold;
    magnitude = d.is_negative ? 16'(17'h10000 - raw) : raw;
    degrees = magnitude[11:4];
    hund = degrees / 100;
    tens = (degrees % 100) / 10;
    units = degrees % 10;
    // sixteenths to tenths, nearest with halves rounded up
    tenths = (int'(magnitude[3:0]) * 10 + 8) / 16;
    d.seg_tenths = segments_of(tenths);
    d.seg_units = segments_of(units) | tts_pkg::SEG_DP;
    d.seg_tens = (hund == 0 && tens == 0) ? tts_pkg::SEG_BLANK : segments_of(tens);
    if (d.is_negative)
      d.seg_hundreds = tts_pkg::SEG_MINUS;
    else
      d.seg_hundreds = (hund == 0) ? tts_pkg::SEG_BLANK : segments_of(hund);
    d.alarm_out = (degrees > limit) ? ~alarm_prev : 1'b0;
    return d;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    display_t want;
    if (!rst_n) begin
      expected_displays.delete();
      neg_threshold = tts_pkg::NEG_THRESHOLD_RST;
      alarm_limit = tts_pkg::ALARM_LIMIT_RST;
      alarm_level = 1'b0;
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tts_pkg::CFG_NEG_THRESHOLD: neg_threshold = cfg_data;
          tts_pkg::CFG_ALARM_LIMIT:   alarm_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_displays.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: display transaction %h with none expected", $time, out_tdata);
        end else begin
          want = expected_displays.pop_front();
          check_field("seg_tenths", want.seg_tenths, out_tdata[7:0]);
          check_field("seg_units", want.seg_units, out_tdata[15:8]);
          check_field("seg_tens", want.seg_tens, out_tdata[23:16]);
          check_field("seg_hundreds", want.seg_hundreds, out_tdata[31:24]);
          check_field("is_negative", 8'(want.is_negative), 8'(out_tdata[32]));
          check_field("alarm_out", 8'(want.alarm_out), 8'(out_tdata[33]));
          check_field("padding", 8'h00, 8'(out_tdata[39:34]));
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_display(in_tdata, neg_threshold, alarm_limit, alarm_level);
        alarm_level = want.alarm_out;
        expected_displays.push_back(want);
      end
    end
    pending_count = expected_displays.size();
  end

endmodule

// File: verif/tb_temperature_to_seven_segment.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temperature_to_seven_segment
// Drives raw readings into the formatter: a directed set of corner readings
// at the reset register values, then random phases under several threshold
// and alarm limit settings, extremes included. Both sides idle at random,
// one phase runs without gaps and one holds the display side off long enough
// to back up the input. The checker predicts and compares every display.
// ----------------------------------------------------------------------------
module tb_temperature_to_seven_segment;

  localparam int PHASE_COUNT = 8;
  localparam int PHASE_READINGS = 128;
  localparam int HOLD_OFF_CYCLES = 80;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [tts_pkg::RAW_W-1:0]      in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [tts_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             mismatch_count;
  int                             pending_count;

  logic [tts_pkg::RAW_W-1:0] cur_threshold;
  logic [7:0]                cur_limit;
  bit                        no_idle;
  bit                        hold_request;

  logic [tts_pkg::RAW_W-1:0] corner_readings [0:23] = '{
    16'h0000, 16'h0001, 16'h0012, 16'h0093, 16'h00a4, 16'h0145, 16'h0156, 16'h0167,
    16'h0178, 16'h0640, 16'h0c88, 16'h0fff, 16'h1009, 16'h18cc, 16'h18cd, 16'hff5e,
    16'hffff, 16'h8000, 16'hfe6a, 16'h7ffb, 16'hfc1c, 16'hf9c0, 16'h000d, 16'h000e
  };

  temperature_to_seven_segment dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  temperature_to_seven_segment_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65)
      return 0;
    else if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [tts_pkg::RAW_W-1:0] random_reading();
    logic [tts_pkg::RAW_W-1:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r = 16'($urandom);
      4, 5:       r = 16'($urandom_range(0, 16'h0fff));
      6, 7:       r = cur_threshold + 16'($urandom_range(0, 4)) - 16'd2;
      8:          r = 16'(17'h10000 - $urandom_range(1, 16'h0fff));
      default:    r = {4'($urandom), cur_limit + 8'($urandom_range(0, 2)) - 8'd1,
                       4'($urandom)};
    endcase
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_reading(input logic [tts_pkg::RAW_W-1:0] raw);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_registers(input logic [tts_pkg::RAW_W-1:0] threshold,
                                   input logic [7:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= tts_pkg::CFG_NEG_THRESHOLD;
    cfg_data <= threshold;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= tts_pkg::CFG_ALARM_LIMIT;
    cfg_data <= {8'h00, limit};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_threshold = threshold;
    cur_limit = limit;
  endtask

  // display side: random stalls plus the long hold-off on request
  initial begin
    int r;
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        if (r < 3)
          stall_left = $urandom_range(10, 30);
        out_tready <= (r >= 20);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = tts_pkg::CFG_NEG_THRESHOLD;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    cur_threshold = tts_pkg::NEG_THRESHOLD_RST;
    cur_limit = tts_pkg::ALARM_LIMIT_RST;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_readings[i])
      send_reading(corner_readings[i]);
    wait_for_drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: program_registers(16'h0000, 8'd0);
        1: program_registers(16'hffff, 8'd255);
        2: program_registers(16'h7fff, 8'd100);
        3: program_registers(tts_pkg::NEG_THRESHOLD_RST, tts_pkg::ALARM_LIMIT_RST);
        default: program_registers(16'($urandom), 8'($urandom_range(0, 160)));
      endcase
      no_idle = (p == 3);
      for (int n = 0; n < PHASE_READINGS; n++) begin
        if (p == 4 && n == 20)
          hold_request = 1'b1;
        send_reading(random_reading());
      end
      wait_for_drain();
    end
    no_idle = 1'b0;

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
